FILE: rtl/core/bmhrq_pkg.sv
package bmhrq_pkg;

	// Field widths of one queue entry
	localparam int KeyWidth    = 32;
	localparam int HandleWidth = 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	typedef enum logic {
		ST_OK   = 1'b0,
		ST_FAIL = 1'b1
	} status_t;

	// Request and response payloads
	typedef struct packed {
		opcode_t                opcode;
		logic [HandleWidth-1:0] thread_handle;
		logic [KeyWidth-1:0]    order_key;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [HandleWidth-1:0] popped_handle;
	} rsp_t;

	// One heap slot as stored in memory
	typedef struct packed {
		logic [KeyWidth-1:0]    key;
		logic [HandleWidth-1:0] handle;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_POP_LOAD,
		S_DN_CHK,
		S_DN_RDR,
		S_DN_CMP,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		RD_ROOT,
		RD_PARENT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_MOVING,
		WR_PARENT,
		WR_CHILD
	} wr_sel_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_PARENT,
		POS_CHILD
	} pos_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     accept;
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		pos_sel_t pos_sel;
		logic     latch_root;
		logic     latch_last;
		logic     latch_left;
		logic     out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_ok;
		logic pop_ok;
		logic pos_root;
		logic ins_less;
		logic lc_ok;
		logic rc_ok;
		logic dn_take;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/core/bmhrq_ram.sv
module bmhrq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/bmhrq_ctrl.sv
module bmhrq_ctrl
	import bmhrq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// Hold the current step of the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through insert, pop and sift steps
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.rd_sel     = RD_ROOT;
		cmd.wr_sel     = WR_NONE;
		cmd.pos_sel    = POS_HOLD;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.ins_ok) begin
						state_d = S_INS_CHK;
					end else if (st.pop_ok) begin
						state_d = S_POP_ROOT;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_INS_CHK: begin
				if (st.pos_root) begin
					cmd.wr_sel = WR_MOVING;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_sel = RD_PARENT;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (st.ins_less) begin
					cmd.wr_sel  = WR_PARENT;
					cmd.pos_sel = POS_PARENT;
					state_d     = S_INS_CHK;
				end else begin
					cmd.wr_sel = WR_MOVING;
					state_d    = S_FINISH;
				end
			end
			S_POP_ROOT: begin
				cmd.rd_sel = RD_ROOT;
				state_d    = S_POP_LAST;
			end
			S_POP_LAST: begin
				cmd.latch_root = 1'b1;
				cmd.rd_sel     = RD_LAST;
				state_d        = S_POP_LOAD;
			end
			S_POP_LOAD: begin
				cmd.latch_last = 1'b1;
				state_d        = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (!st.lc_ok) begin
					cmd.wr_sel = WR_MOVING;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_sel = RD_LEFT;
					state_d    = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				cmd.latch_left = 1'b1;
				cmd.rd_sel     = RD_RIGHT;
				state_d        = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (st.dn_take) begin
					cmd.wr_sel  = WR_CHILD;
					cmd.pos_sel = POS_CHILD;
					state_d     = S_DN_CHK;
				end else begin
					cmd.wr_sel = WR_MOVING;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/bmhrq_dp.sv
module bmhrq_dp
	import bmhrq_pkg::*;
#(
	parameter int HEAP_DEPTH = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  in_data,
	input  logic  out_ready,
	output logic  out_valid,
	output rsp_t  out_data,
	input  cmd_t  cmd,
	output stat_t st
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = AW + 2;

	// Control registers
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// Payload registers
	logic [AW-1:0]          pos_q;
	entry_t                 mov_q;
	entry_t                 left_q;
	status_t                res_status_q;
	logic [HandleWidth-1:0] res_handle_q;
	rsp_t                   out_q;

	// Memory port
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	entry_t        wr_data;
	entry_t        rd_data;

	// Index arithmetic
	logic [AW-1:0] pos_m1;
	logic [AW-1:0] parent_idx;
	logic [IW-1:0] lc_idx;
	logic [IW-1:0] rc_idx;
	logic [IW-1:0] count_ext;
	logic [IW-1:0] child_idx;

	// Sift-down decision
	logic                rc_ok;
	logic                left_less;
	logic [KeyWidth-1:0] best_key;
	logic                dn_right;
	entry_t              child_entry;

	assign pos_m1     = pos_q - 1'b1;
	assign parent_idx = pos_m1 >> 1;
	assign lc_idx     = {1'b0, pos_q, 1'b1};
	assign rc_idx     = lc_idx + 1'b1;
	assign count_ext  = {{(IW - CW){1'b0}}, count_q};
	assign rc_ok      = rc_idx < count_ext;

	// Pick the smaller child; left wins a tie
	assign left_less   = left_q.key < mov_q.key;
	assign best_key    = left_less ? left_q.key : mov_q.key;
	assign dn_right    = rc_ok && (rd_data.key < best_key);
	assign child_idx   = dn_right ? rc_idx : lc_idx;
	assign child_entry = dn_right ? rd_data : left_q;

	// Status back to the controller
	always_comb begin
		st          = '0;
		st.full     = count_q == CW'(HEAP_DEPTH);
		st.empty    = count_q == '0;
		st.ins_ok   = (in_data.opcode == OP_INSERT) && !st.full;
		st.pop_ok   = (in_data.opcode == OP_POP) && !st.empty;
		st.pos_root = pos_q == '0;
		st.ins_less = mov_q.key < rd_data.key;
		st.lc_ok    = lc_idx < count_ext;
		st.rc_ok    = rc_ok;
		st.dn_take  = left_less || dn_right;
		st.out_free = !out_valid_q || out_ready;
	end

	// Select read address
	always_comb begin
		unique case (cmd.rd_sel)
			RD_ROOT:   rd_addr = '0;
			RD_PARENT: rd_addr = parent_idx;
			RD_LAST:   rd_addr = count_q[AW-1:0];
			RD_LEFT:   rd_addr = lc_idx[AW-1:0];
			RD_RIGHT:  rd_addr = rc_idx[AW-1:0];
			default:   rd_addr = '0;
		endcase
	end

	// Select write data; every write lands on the hole position
	always_comb begin
		wr_en = 1'b1;
		unique case (cmd.wr_sel)
			WR_MOVING: wr_data = mov_q;
			WR_PARENT: wr_data = rd_data;
			WR_CHILD:  wr_data = child_entry;
			default: begin
				wr_en   = 1'b0;
				wr_data = mov_q;
			end
		endcase
	end

	bmhrq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (pos_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Track entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (st.ins_ok) begin
					count_q <= count_q + 1'b1;
				end else if (st.pop_ok) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Move the hole, latch entries and the result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mov_q.key    <= in_data.order_key;
			mov_q.handle <= in_data.thread_handle;
			res_handle_q <= '0;
			res_status_q <= (st.ins_ok || st.pop_ok) ? ST_OK : ST_FAIL;
			if (st.ins_ok) begin
				pos_q <= count_q[AW-1:0];
			end
		end
		unique case (cmd.pos_sel)
			POS_PARENT: pos_q <= parent_idx;
			POS_CHILD:  pos_q <= child_idx[AW-1:0];
			default: begin
			end
		endcase
		if (cmd.latch_root) begin
			res_handle_q <= rd_data.handle;
		end
		if (cmd.latch_last) begin
			mov_q <= rd_data;
			pos_q <= '0;
		end
		if (cmd.latch_left) begin
			left_q <= rd_data;
		end
		if (cmd.out_load) begin
			out_q.status        <= res_status_q;
			out_q.popped_handle <= res_handle_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/core/binary_min_heap_ready_queue.sv
// An insert climbs one level per parent compare, stopping at the root or below a parent whose
// key is no larger; a pop moves the last entry to the root and sinks it one level per child
// compare until no child is smaller or it has no child; a failed request goes to the response.
// Throughput: one request at a time; each sift level reads the single-read-port heap memory
// once per key compared (parent, or left then right child) and then decides.
// Reset: entry count and output valid clear at once; heap memory is not reset.
module binary_min_heap_ready_queue
	import bmhrq_pkg::*;
#(
	parameter int HEAP_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	cmd_t  cmd;
	stat_t st;

	bmhrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	bmhrq_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

`ifndef ASSERT_OFF
	// A failed request never returns a handle
	a_fail_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FAIL) |-> out_data.popped_handle == '0)
		else $error("failed response carries a nonzero handle");

	// A successful insert leaves the heap nonempty
	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.opcode == OP_INSERT) && !st.full |=> !st.empty)
		else $error("heap empty after successful insert");

	// A successful pop leaves room for an insert
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.opcode == OP_POP) && !st.empty |=> !st.full)
		else $error("heap full after successful pop");
`endif

endmodule
